// File: src/mono_framebuffer_draw_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome framebuffer draw engine
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfb assertion failed");
`define MFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfb assertion failed");
`else
`define MFB_ASSERT_NOW(lbl, ante, cons)
`define MFB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants of the monochrome framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int FIELD_W = 12;
  localparam int GEOM_W  = 14;
  localparam int COORD_W = 11;

  typedef enum logic [2:0] {
    CMD_CLEAR     = 3'd0,
    CMD_FILL      = 3'd1,
    CMD_READ_CUR  = 3'd2,
    CMD_READ_PREV = 3'd3,
    CMD_PLAN      = 3'd4,
    CMD_COMMIT    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_FILL_SETUP,
    ST_FILL_ROW,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_READ_WAIT,
    ST_COPY,
    ST_COPY_END,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [10:0] w;
    logic [10:0] h;
  } win_t;

  typedef struct packed {
    logic               empty;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       addr_error;
    win_t       win;
  } res_t;

endpackage

// File: src/mfb_geom.sv
// ----------------------------------------------------------------------------
// mfb_geom
// Clips a signed rectangle to the screen for filling and plans the
// byte-aligned partial refresh window from the same coordinates.
// ----------------------------------------------------------------------------
module mfb_geom #(
  parameter int SCREEN_WIDTH  = 400,
  parameter int SCREEN_HEIGHT = 300
) (
  input  logic signed [mfb_pkg::FIELD_W-1:0] pos_x,
  input  logic signed [mfb_pkg::FIELD_W-1:0] pos_y,
  input  logic signed [mfb_pkg::FIELD_W-1:0] size_w,
  input  logic signed [mfb_pkg::FIELD_W-1:0] size_h,
  output mfb_pkg::win_t                      win,
  output mfb_pkg::rect_t                     rect
);

  localparam logic signed [mfb_pkg::GEOM_W-1:0] W_S = mfb_pkg::GEOM_W'(SCREEN_WIDTH);
  localparam logic signed [mfb_pkg::GEOM_W-1:0] H_S = mfb_pkg::GEOM_W'(SCREEN_HEIGHT);

  logic signed [mfb_pkg::GEOM_W-1:0] xe, ye, we, he;
  logic signed [mfb_pkg::GEOM_W-1:0] xc, yc, xend, yend, x1, y1, wc, hc;
  logic                              pos_size, win_ok;

  always_comb begin
    xe = {{2{pos_x[11]}}, pos_x};
    ye = {{2{pos_y[11]}}, pos_y};
    we = {{2{size_w[11]}}, size_w};
    he = {{2{size_h[11]}}, size_h};
    xc = xe[mfb_pkg::GEOM_W-1] ? '0 : xe;
    yc = ye[mfb_pkg::GEOM_W-1] ? '0 : ye;
    pos_size = (we > 14'sd0) && (he > 14'sd0);

    xend = xe + we;
    yend = ye + he;
    x1 = (xend > W_S) ? W_S : xend;
    y1 = (yend > H_S) ? H_S : yend;
    rect.empty = !pos_size || (xc >= x1) || (yc >= y1);
    rect.x0 = xc[mfb_pkg::COORD_W-1:0];
    rect.x1 = x1[mfb_pkg::COORD_W-1:0];
    rect.y0 = yc[mfb_pkg::COORD_W-1:0];
    rect.y1 = y1[mfb_pkg::COORD_W-1:0];

    wc = ((xc + we) > W_S) ? (W_S - xc) : we;
    hc = ((yc + he) > H_S) ? (H_S - yc) : he;
    win_ok = pos_size && (wc >= 14'sd8) && (hc >= 14'sd1);
    win.valid = win_ok;
    win.x = win_ok ? {xc[9:3], 3'b000} : '0;
    win.y = win_ok ? yc[9:0] : '0;
    win.w = win_ok ? {wc[10:3], 3'b000} : '0;
    win.h = win_ok ? hc[10:0] : '0;
  end

endmodule

// File: src/mono_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Two 1-bit-per-pixel framebuffers (current and previous, MSB first, 1 is
// white) with clear, clipped rectangle fill, byte read, refresh window
// planning and commit. One result beat is returned for every command beat.
// After reset the block writes white into every byte of both buffers with
// in_stall high. A fill does a read-modify-write of every byte touched in
// each clipped row, since it has only the single read and single write port
// of the current buffer. A new command beat is taken while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_draw_engine_assert.svh"

module mono_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 400,
  parameter int SCREEN_HEIGHT = 300
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic signed [11:0] in_size_w,
  input  logic signed [11:0] in_size_h,
  input  logic               in_ink_black,
  input  logic [16:0]        in_byte_addr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_read_byte,
  output logic               out_addr_error,
  output logic               out_win_valid,
  output logic [9:0]         out_win_x,
  output logic [9:0]         out_win_y,
  output logic [10:0]        out_win_w,
  output logic [10:0]        out_win_h
);

  localparam int FB_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
  localparam int AW       = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
  localparam int PIX_W    = AW + 3;
  localparam logic [AW-1:0] LAST_ADDR = AW'(FB_BYTES - 1);
  localparam logic [17:0]   FB_LIMIT  = 18'(FB_BYTES);

  mfb_pkg::state_t state_r, state_nxt;
  mfb_pkg::cmd_t   cmd_r;
  logic signed [11:0] pos_x_r, pos_y_r, size_w_r, size_h_r;
  logic               ink_r;
  logic [16:0]        addr_r;

  logic [AW-1:0]               baddr_r, baddr_nxt;
  logic [AW-1:0]               last_r, last_nxt;
  logic [2:0]                  lo_r, lo_nxt;
  logic [2:0]                  hi_last_r, hi_last_nxt;
  logic [mfb_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0]            row_base_r, row_base_nxt;
  logic                        cp_vld_r, cp_vld_nxt;
  logic [AW-1:0]               cp_addr_r;
  mfb_pkg::res_t               res_r, res_nxt;
  mfb_pkg::res_t               out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [7:0]    cur_mem [FB_BYTES];
  logic [7:0]    prev_mem [FB_BYTES];
  logic [7:0]    cur_rdata_r, prev_rdata_r;
  logic          cur_we, prev_we;
  logic [AW-1:0] cur_waddr, prev_waddr, cur_raddr, prev_raddr;
  logic [7:0]    cur_wdata, prev_wdata;

  mfb_pkg::win_t  win;
  mfb_pkg::rect_t rect;

  logic             accept, out_free, addr_bad, byte_last, row_last;
  logic [PIX_W-1:0] seg_start, seg_last;
  logic [3:0]       hi;
  logic [7:0]       mask;

  mfb_geom #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_geom (
    .pos_x  (pos_x_r),
    .pos_y  (pos_y_r),
    .size_w (size_w_r),
    .size_h (size_h_r),
    .win    (win),
    .rect   (rect)
  );

  assign in_stall = (state_r != mfb_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign addr_bad = ({1'b0, addr_r} >= FB_LIMIT);
  assign byte_last = (baddr_r == last_r);
  assign row_last  = ((row_r + 11'd1) == rect.y1);

  assign seg_start = row_base_r + PIX_W'(rect.x0);
  assign seg_last  = row_base_r + PIX_W'(rect.x1 - 11'd1);
  assign hi        = byte_last ? ({1'b0, hi_last_r} + 4'd1) : 4'd8;
  assign mask      = (8'hFF >> lo_r) & ~(8'hFF >> hi);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfb_pkg::ST_INIT: begin
        if (baddr_r == LAST_ADDR) state_nxt = mfb_pkg::ST_IDLE;
      end
      mfb_pkg::ST_IDLE: begin
        if (accept) state_nxt = mfb_pkg::ST_DECODE;
      end
      mfb_pkg::ST_DECODE: begin
        case (cmd_r)
          mfb_pkg::CMD_CLEAR:  state_nxt = mfb_pkg::ST_CLEAR;
          mfb_pkg::CMD_FILL: begin
            state_nxt = rect.empty ? mfb_pkg::ST_RESULT : mfb_pkg::ST_FILL_SETUP;
          end
          mfb_pkg::CMD_READ_CUR, mfb_pkg::CMD_READ_PREV: begin
            state_nxt = addr_bad ? mfb_pkg::ST_RESULT : mfb_pkg::ST_READ_WAIT;
          end
          mfb_pkg::CMD_COMMIT: state_nxt = mfb_pkg::ST_COPY;
          default:             state_nxt = mfb_pkg::ST_RESULT;
        endcase
      end
      mfb_pkg::ST_CLEAR: begin
        if (baddr_r == LAST_ADDR) state_nxt = mfb_pkg::ST_RESULT;
      end
      mfb_pkg::ST_FILL_SETUP: state_nxt = mfb_pkg::ST_FILL_ROW;
      mfb_pkg::ST_FILL_ROW:   state_nxt = mfb_pkg::ST_FILL_RD;
      mfb_pkg::ST_FILL_RD:    state_nxt = mfb_pkg::ST_FILL_WR;
      mfb_pkg::ST_FILL_WR: begin
        if (!byte_last) begin
          state_nxt = mfb_pkg::ST_FILL_RD;
        end else if (row_last) begin
          state_nxt = mfb_pkg::ST_RESULT;
        end else begin
          state_nxt = mfb_pkg::ST_FILL_ROW;
        end
      end
      mfb_pkg::ST_READ_WAIT: state_nxt = mfb_pkg::ST_RESULT;
      mfb_pkg::ST_COPY: begin
        if (baddr_r == LAST_ADDR) state_nxt = mfb_pkg::ST_COPY_END;
      end
      mfb_pkg::ST_COPY_END: state_nxt = mfb_pkg::ST_RESULT;
      mfb_pkg::ST_RESULT: begin
        if (out_free) state_nxt = mfb_pkg::ST_IDLE;
      end
      default: state_nxt = mfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    baddr_nxt     = baddr_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_last_nxt   = hi_last_r;
    row_nxt       = row_r;
    row_base_nxt  = row_base_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cp_vld_nxt    = (state_r == mfb_pkg::ST_COPY);
    cur_we        = 1'b0;
    cur_waddr     = baddr_r;
    cur_wdata     = 8'hFF;
    cur_raddr     = baddr_r;
    prev_we       = cp_vld_r;
    prev_waddr    = cp_addr_r;
    prev_wdata    = cur_rdata_r;
    prev_raddr    = addr_r[AW-1:0];

    case (state_r)
      mfb_pkg::ST_INIT: begin
        cur_we     = 1'b1;
        prev_we    = 1'b1;
        prev_waddr = baddr_r;
        prev_wdata = 8'hFF;
        baddr_nxt  = baddr_r + 1'b1;
      end
      mfb_pkg::ST_IDLE: begin
        if (accept) res_nxt = '0;
      end
      mfb_pkg::ST_DECODE: begin
        baddr_nxt = '0;
        cur_raddr = addr_r[AW-1:0];
        case (cmd_r)
          mfb_pkg::CMD_FILL:   row_nxt = rect.y0;
          mfb_pkg::CMD_READ_CUR, mfb_pkg::CMD_READ_PREV: begin
            res_nxt.addr_error = addr_bad;
          end
          mfb_pkg::CMD_PLAN:   res_nxt.win = win;
          default:             res_nxt = res_r;
        endcase
      end
      mfb_pkg::ST_CLEAR: begin
        cur_we    = 1'b1;
        cur_wdata = ink_r ? 8'h00 : 8'hFF;
        baddr_nxt = baddr_r + 1'b1;
      end
      mfb_pkg::ST_FILL_SETUP: begin
        row_base_nxt = PIX_W'(row_r * SCREEN_WIDTH);
      end
      mfb_pkg::ST_FILL_ROW: begin
        baddr_nxt   = seg_start[PIX_W-1:3];
        last_nxt    = seg_last[PIX_W-1:3];
        lo_nxt      = seg_start[2:0];
        hi_last_nxt = seg_last[2:0];
      end
      mfb_pkg::ST_FILL_WR: begin
        cur_we    = 1'b1;
        cur_wdata = ink_r ? (cur_rdata_r & ~mask) : (cur_rdata_r | mask);
        lo_nxt    = 3'd0;
        if (byte_last) begin
          row_nxt      = row_r + 11'd1;
          row_base_nxt = row_base_r + PIX_W'(SCREEN_WIDTH);
        end else begin
          baddr_nxt = baddr_r + 1'b1;
        end
      end
      mfb_pkg::ST_READ_WAIT: begin
        res_nxt.read_byte = (cmd_r == mfb_pkg::CMD_READ_CUR) ? cur_rdata_r : prev_rdata_r;
      end
      mfb_pkg::ST_COPY: begin
        baddr_nxt = baddr_r + 1'b1;
      end
      mfb_pkg::ST_RESULT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfb_pkg::ST_INIT;
      baddr_r     <= '0;
      out_valid_r <= 1'b0;
      cp_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      baddr_r     <= baddr_nxt;
      out_valid_r <= out_valid_nxt;
      cp_vld_r    <= cp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= mfb_pkg::cmd_t'(in_cmd);
      pos_x_r  <= in_pos_x;
      pos_y_r  <= in_pos_y;
      size_w_r <= in_size_w;
      size_h_r <= in_size_h;
      ink_r    <= in_ink_black;
      addr_r   <= in_byte_addr;
    end
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_last_r  <= hi_last_nxt;
    row_r      <= row_nxt;
    row_base_r <= row_base_nxt;
    cp_addr_r  <= baddr_r;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    cur_rdata_r <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_rdata_r <= prev_mem[prev_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_read_byte  = out_r.read_byte;
  assign out_addr_error = out_r.addr_error;
  assign out_win_valid  = out_r.win.valid;
  assign out_win_x      = out_r.win.x;
  assign out_win_y      = out_r.win.y;
  assign out_win_w      = out_r.win.w;
  assign out_win_h      = out_r.win.h;

  // Both buffers are written together only by the clearing pass after reset.
  `MFB_ASSERT_NOW(a_dual_write_init, cur_we && prev_we, state_r == mfb_pkg::ST_INIT)
  `MFB_ASSERT_NOW(a_fill_in_span, state_r == mfb_pkg::ST_FILL_WR, baddr_r <= last_r)
  `MFB_ASSERT_NEXT(a_accept_decode, accept, state_r == mfb_pkg::ST_DECODE)
  `MFB_ASSERT_NOW(a_copy_addr, prev_we && (state_r != mfb_pkg::ST_INIT),
                  prev_waddr == $past(cur_raddr))
  `MFB_ASSERT_NOW(a_win_shape, out_valid_r && out_r.win.valid,
                  (out_r.win.w != 11'd0) && (out_r.win.h != 11'd0) &&
                  (out_r.win.w[2:0] == 3'd0))

endmodule
